>>> hw/rtl/mppg_pkg.sv
// Shared types and constants for the marker pattern pixel generator.
package mppg_pkg;

    localparam int unsigned X_W       = 15;
    localparam int unsigned PAGE_W    = 9;
    localparam int unsigned TILE_IDX_W = 6;
    localparam int unsigned ACROSS_W  = 7;
    localparam int unsigned TILE_BASE = 160;

    // x / 5 == (x * RECIP5) >> RECIP5_SH for every 15-bit x
    localparam logic [15:0] RECIP5    = 16'd52429;
    localparam int unsigned RECIP5_SH = 18;
    // p / 5 == (p * RECIP_SMALL) >> 10 and p / 10 == (p * RECIP_SMALL) >> 11 for p < 256
    localparam logic [7:0]  RECIP_SMALL = 8'd205;

    localparam logic [8:0] ID_MASK_ODD  = 9'd170;
    localparam logic [8:0] ID_MASK_EVEN = 9'd340;
    localparam logic [3:0] ROW_MUL      = 4'd13;
    localparam logic [2:0] COL_MUL      = 3'd7;
    localparam logic [2:0] CENTER       = 3'd2;
    localparam logic [2:0] EDGE_COL     = 3'd4;

    typedef enum logic
    {
        REG_BASE_PAGE    = 1'b0,
        REG_TILES_ACROSS = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic              vld;
        logic              oor;
        logic              flip;
        logic [X_W-1:0]    x;
        logic [X_W-1:0]    y;
        logic [PAGE_W-1:0] page;
    } item_t;

endpackage

>>> hw/rtl/mppg_cell.sv
// One downscale cell: divide the coordinates by five and track the center flip.
module mppg_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  mppg_pkg::item_t in_item,
    output mppg_pkg::item_t out_item
);

    logic [30:0]                  prod_x;
    logic [30:0]                  prod_y;
    logic [mppg_pkg::X_W-1:0]     qx;
    logic [mppg_pkg::X_W-1:0]     qy;
    logic [2:0]                   rx;
    logic [2:0]                   ry;
    mppg_pkg::item_t              item_next;
    mppg_pkg::item_t              item_reg;

    always_comb
    begin
        prod_x = 31'(in_item.x) * 31'(mppg_pkg::RECIP5);
        prod_y = 31'(in_item.y) * 31'(mppg_pkg::RECIP5);
        qx = 15'(prod_x[30:mppg_pkg::RECIP5_SH]);
        qy = 15'(prod_y[30:mppg_pkg::RECIP5_SH]);
        rx = 3'(in_item.x - ((qx << 2) + qx));
        ry = 3'(in_item.y - ((qy << 2) + qy));
        item_next = in_item;
        item_next.x = qx;
        item_next.y = qy;
        item_next.flip = in_item.flip ^ ((rx == mppg_pkg::CENTER) && (ry == mppg_pkg::CENTER));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

    assign out_item = item_reg;

endmodule

>>> hw/rtl/mppg_base.sv
// Base image stage: marker cell lookup and final pixel register.
module mppg_base
(
    input  logic            clk,
    input  logic            rst_n,
    input  mppg_pkg::item_t in_item,
    output logic            done,
    output logic            white
);

    logic [7:0]  px;
    logic [7:0]  py;
    logic [15:0] prod_px;
    logic [15:0] prod_py;
    logic [4:0]  col;
    logic [3:0]  row;
    logic [2:0]  cx;
    logic [3:0]  rr;
    logic [2:0]  cy;
    logic        half;
    logic        odd;
    logic [8:0]  id;
    logic [4:0]  r;
    logic [8:0]  mix;
    logic [8:0]  code;
    logic        inv;
    logic [3:0]  bit_idx;
    logic        v;
    logic        white_next;
    logic        done_reg;
    logic        white_reg;

    always_comb
    begin
        px = in_item.x[7:0];
        py = in_item.y[7:0];
        prod_px = 16'(px) * 16'(mppg_pkg::RECIP_SMALL);
        prod_py = 16'(py) * 16'(mppg_pkg::RECIP_SMALL);
        col = prod_px[14:10];
        row = prod_py[14:11];
        cx = 3'(px - ((8'(col) << 2) + 8'(col)));
        rr = 4'(py - ((8'(row) << 3) + (8'(row) << 1)));
        half = (rr >= 4'd5);
        cy = half ? 3'(rr - 4'd5) : rr[2:0];
        odd = col[0];
        id = {row, col};
        r = {row, ~odd};
        mix = 9'(9'(r) * 9'(mppg_pkg::ROW_MUL)) + 9'(9'(col) * 9'(mppg_pkg::COL_MUL));
        if (half == odd)
        begin
            code = odd ? (id ^ mppg_pkg::ID_MASK_ODD) : (id ^ mppg_pkg::ID_MASK_EVEN);
            inv = 1'b0;
        end
        else
        begin
            code = in_item.page ^ mix;
            inv = 1'b1;
        end
        bit_idx = 4'((4'(cy) - 4'd1) * 4'd3 + (4'(cx) - 4'd1));
        if (cy inside {[3'd1:3'd3]} && cx inside {[3'd1:3'd3]})
        begin
            v = code[bit_idx];
        end
        else if (cy == mppg_pkg::CENTER && cx == mppg_pkg::EDGE_COL)
        begin
            v = 1'b1;
        end
        else
        begin
            v = 1'b0;
        end
        white_next = in_item.oor ? 1'b1 : (v ^ inv ^ in_item.flip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_item.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        white_reg <= white_next;
    end

    assign done  = done_reg;
    assign white = white_reg;

endmodule

>>> hw/rtl/marker_pattern_pixel_generator.sv
// Top level: config registers, entry stage, downscale cell chain and base stage.
// Path: start is registered in the entry stage, in each downscale cell and in the done register of the base stage.
// Throughput: one item per cycle; busy stays low, each downscale cell is one stage.
// Reset: rst_n clears all stage valid bits and sets base_page = 0, tiles_across = 1.
// The receiver cannot stall; each result shows on done/white for one cycle.
module marker_pattern_pixel_generator
#(
    parameter int LEVELS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [5:0]  tile_col,
    input  logic [5:0]  tile_row,
    input  logic [14:0] pixel_x,
    input  logic [14:0] pixel_y,
    output logic        done,
    output logic        white,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam longint unsigned EDGE = 64'(mppg_pkg::TILE_BASE) * (64'd5 ** LEVELS);

    logic [8:0]      base_page_reg;
    logic [6:0]      tiles_across_reg;
    logic            cfg_wr;
    logic [12:0]     row_off;
    mppg_pkg::item_t entry_next;
    mppg_pkg::item_t entry_reg;
    mppg_pkg::item_t stage [0:LEVELS];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_page_reg    <= '0;
            tiles_across_reg <= 7'd1;
        end
        else if (cfg_wr)
        begin
            case (mppg_pkg::reg_idx_t'(paddr[2]))
                mppg_pkg::REG_BASE_PAGE:    base_page_reg    <= pwdata[8:0];
                mppg_pkg::REG_TILES_ACROSS: tiles_across_reg <= pwdata[6:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (mppg_pkg::reg_idx_t'(paddr[2]))
            mppg_pkg::REG_BASE_PAGE:    prdata = 32'(base_page_reg);
            mppg_pkg::REG_TILES_ACROSS: prdata = 32'(tiles_across_reg);
            default:                    prdata = '0;
        endcase
    end

    always_comb
    begin
        row_off = 13'(tile_row) * 13'(tiles_across_reg);
        entry_next.vld  = start && !busy;
        entry_next.oor  = (64'(pixel_x) >= EDGE) || (64'(pixel_y) >= EDGE);
        entry_next.flip = 1'b0;
        entry_next.x    = pixel_x;
        entry_next.y    = pixel_y;
        entry_next.page = base_page_reg + row_off[8:0] + 9'(tile_col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign stage[0] = entry_reg;

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_cell
        mppg_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_item  (stage[g]),
            .out_item (stage[g+1])
        );
    end

    mppg_base u_base
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (stage[LEVELS]),
        .done    (done),
        .white   (white)
    );

endmodule

>>> hw/rtl/mppg_checker.sv
// Port-level checker for the marker pattern pixel generator, bound to the top level.
module mppg_port_checker
#(
    parameter int LEVELS = 3
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [14:0] pixel_x,
    input logic [14:0] pixel_y,
    input logic        done,
    input logic        white,
    input logic        pready
);

    localparam int LAT = LEVELS + 2;
    localparam longint unsigned EDGE = 64'd160 * (64'd5 ** LEVELS);

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy && pready)
        else $error("busy or pready shows a stall");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("done without a matching item");

    a_item_gets_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("item dropped");

    a_outside_white: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((64'(pixel_x) >= EDGE) || (64'(pixel_y) >= EDGE)))
        |-> ##LAT white)
        else $error("pixel outside tile is not white");

endmodule

bind marker_pattern_pixel_generator mppg_port_checker #(.LEVELS(LEVELS)) u_mppg_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .done    (done),
    .white   (white),
    .pready  (pready)
);

>>> verif/mppg_checker.sv
// Checker for the marker pattern pixel generator: mirrors config, predicts each pixel, compares.
module mppg_checker
#(
    parameter int LEVELS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [5:0]  tile_col,
    input  logic [5:0]  tile_row,
    input  logic [14:0] pixel_x,
    input  logic [14:0] pixel_y,
    input  logic        done,
    input  logic        white,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    logic [mppg_pkg::PAGE_W-1:0]   cfg_base_page;
    logic [mppg_pkg::ACROSS_W-1:0] cfg_tiles_across;
    logic                          expected_white[$];

    function automatic logic predict_white(input logic [5:0] tcol, input logic [5:0] trow,
                                           input logic [14:0] px, input logic [14:0] py);
        int unsigned span;
        int unsigned x;
        int unsigned y;
        int unsigned flips;
        int unsigned page;
        int unsigned col;
        int unsigned cx;
        int unsigned row;
        int unsigned rr;
        int unsigned cy;
        int unsigned id;
        int unsigned code;
        int unsigned r;
        int unsigned v;
        int unsigned odd;
        int unsigned inv;
        span = mppg_pkg::TILE_BASE;
        for (int k = 0; k < LEVELS; k++)
            span = span * 5;
        if (px >= span || py >= span)
            return 1'b1;
        x = px;
        y = py;
        flips = 0;
        for (int k = 0; k < LEVELS; k++)
        begin
            if (x % 5 == mppg_pkg::CENTER && y % 5 == mppg_pkg::CENTER)
                flips = flips ^ 1;
            x = x / 5;
            y = y / 5;
        end
        page = (cfg_base_page + trow * cfg_tiles_across + tcol) & 511;
        col = x / 5;
        cx = x % 5;
        row = y / 10;
        rr = y % 10;
        cy = rr % 5;
        odd = col & 1;
        id = row * 32 + col;
        if (rr / 5 == odd)
        begin
            code = (odd != 0) ? (id ^ mppg_pkg::ID_MASK_ODD) : (id ^ mppg_pkg::ID_MASK_EVEN);
            inv = 0;
        end
        else
        begin
            r = row * 2 + ((odd != 0) ? 0 : 1);
            code = page ^ ((r * mppg_pkg::ROW_MUL + col * mppg_pkg::COL_MUL) & 511);
            inv = 1;
        end
        code = code & 511;
        if (cy >= 1 && cy <= 3 && cx >= 1 && cx <= 3)
            v = (code >> ((cy - 1) * 3 + (cx - 1))) & 1;
        else if (cy == mppg_pkg::CENTER && cx == mppg_pkg::EDGE_COL)
            v = 1;
        else
            v = 0;
        return logic'((v ^ inv ^ flips) & 1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic exp_white;
        if (!rst_n)
        begin
            cfg_base_page    <= '0;
            cfg_tiles_across <= 7'd1;
            fail_count       <= 0;
            pending          <= 0;
            expected_white.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_white.size() == 0)
                begin
                    $display("%0t: unexpected pixel, expected none actual %0b", $time, white);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_white = expected_white.pop_front();
                    if (white !== exp_white)
                    begin
                        $display("%0t: white mismatch, expected %0b actual %0b",
                                 $time, exp_white, white);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_white.push_back(predict_white(tile_col, tile_row, pixel_x, pixel_y));
            if (psel && penable && pwrite && pready)
            begin
                if (mppg_pkg::reg_idx_t'(paddr[2]) == mppg_pkg::REG_BASE_PAGE)
                    cfg_base_page <= pwdata[mppg_pkg::PAGE_W-1:0];
                else
                    cfg_tiles_across <= pwdata[mppg_pkg::ACROSS_W-1:0];
            end
            pending <= expected_white.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// Testbench top: drives pixel items and register writes, gives the verdict.
module tb_top;

    localparam int LEVELS    = 3;
    localparam int SPAN      = 160 * (5 ** LEVELS);
    localparam int CYCLE_CAP = 200000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [5:0]  tile_col;
    logic [5:0]  tile_row;
    logic [14:0] pixel_x;
    logic [14:0] pixel_y;
    logic        done;
    logic        white;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles = 0;

    marker_pattern_pixel_generator #(.LEVELS(LEVELS)) u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .tile_col (tile_col),
        .tile_row (tile_row),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .done     (done),
        .white    (white),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mppg_checker #(.LEVELS(LEVELS)) u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .tile_col   (tile_col),
        .tile_row   (tile_row),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .done       (done),
        .white      (white),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_pixel(input logic [5:0] tcol, input logic [5:0] trow,
                              input logic [14:0] px, input logic [14:0] py);
        start    <= 1'b1;
        tile_col <= tcol;
        tile_row <= trow;
        pixel_x  <= px;
        pixel_y  <= py;
        do @(posedge clk); while (busy);
    endtask

    task automatic hold_off();
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
    endtask

    // drain every outstanding pixel before touching the registers
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input mppg_pkg::reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // bias toward base-5 digit 2 so block centers get hit at every level
    function automatic logic [14:0] pick_coord();
        int unsigned sel;
        int unsigned off;
        int unsigned digit;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 15'($urandom_range(SPAN, 32767));
        if (sel < 4)
            return 15'($urandom_range(0, SPAN - 1));
        off = 0;
        for (int k = 0; k < LEVELS; k++)
        begin
            digit = ($urandom_range(0, 2) == 0) ? 2 : $urandom_range(0, 4);
            off = off * 5 + digit;
        end
        return 15'($urandom_range(0, 159) * (SPAN / 160) + off);
    endfunction

    task automatic run_directed();
        send_pixel(6'd0, 6'd0, 15'd0, 15'd0);
        send_pixel(6'd63, 6'd63, 15'(SPAN - 1), 15'(SPAN - 1));
        send_pixel(6'd0, 6'd0, 15'(SPAN), 15'd0);
        send_pixel(6'd0, 6'd0, 15'd0, 15'(SPAN));
        send_pixel(6'd63, 6'd63, 15'h7fff, 15'h7fff);
        send_pixel(6'd5, 6'd9, 15'd62, 15'd62);
        send_pixel(6'd1, 6'd2, 15'd500, 15'd250);
        send_pixel(6'd2, 6'd1, 15'd750, 15'd750);
        send_pixel(6'd3, 6'd4, 15'd750, 15'd125);
        send_pixel(6'd63, 6'd0, 15'd875, 15'd875);
        send_pixel(6'd0, 6'd63, 15'd875, 15'd250);
        send_pixel(6'd17, 6'd42, 15'(159 * 125 + 62), 15'(159 * 125 + 62));
        send_pixel(6'd42, 6'd17, 15'(157 * 125 + 12), 15'(152 * 125 + 12));
    endtask

    task automatic run_random(input int count, input bit steady);
        for (int n = 0; n < count; n++)
        begin
            if (!steady && $urandom_range(0, 3) == 0)
                hold_off();
            send_pixel(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                       pick_coord(), pick_coord());
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    <= 1'b0;
        tile_col <= '0;
        tile_row <= '0;
        pixel_x  <= '0;
        pixel_y  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(300, 1'b0);
        drain();

        write_reg(mppg_pkg::REG_BASE_PAGE, 32'd511);
        write_reg(mppg_pkg::REG_TILES_ACROSS, 32'd127);
        run_directed();
        run_random(300, 1'b0);
        drain();

        write_reg(mppg_pkg::REG_BASE_PAGE, 32'd0);
        write_reg(mppg_pkg::REG_TILES_ACROSS, 32'd0);
        run_random(300, 1'b0);
        drain();

        write_reg(mppg_pkg::REG_BASE_PAGE, $urandom_range(0, 511));
        write_reg(mppg_pkg::REG_TILES_ACROSS, 32'd64);
        run_random(300, 1'b0);
        drain();

        write_reg(mppg_pkg::REG_TILES_ACROSS, $urandom_range(1, 127));
        write_reg(mppg_pkg::REG_BASE_PAGE, $urandom_range(0, 511));
        run_random(200, 1'b0);
        run_random(200, 1'b1);

        drain();
        repeat (LEVELS + 4) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
